@@ src/brb_pkg.sv @@
`timescale 1ns / 1ps
package brb_pkg;

  localparam int unsigned CapW         = 11;
  localparam int unsigned CountW       = 10;
  localparam int unsigned PctW         = 7;
  localparam int unsigned ByteW        = 8;
  // count * 100 with count below capacity fits here
  localparam int unsigned NumW         = CapW + PctW;
  localparam int unsigned DefDepth     = 1024;
  localparam int unsigned CapReset     = 1024;
  localparam int unsigned PercentScale = 100;

  typedef enum logic [1:0] {
    CmdPush  = 2'd0,
    CmdPop   = 2'd1,
    CmdPeek  = 2'd2,
    CmdQuery = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e             command;
    logic [ByteW-1:0] write_byte;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0]  read_byte;
    logic              success;
    logic [CountW-1:0] fill_count;
    logic [PctW-1:0]   fill_percent;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic exec;
    logic fill_load;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/brb_ctrl.sv @@
`timescale 1ns / 1ps
module brb_ctrl
  import brb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_DIV,
    S_HOLD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o.idle      = (state_q == S_IDLE);
    cmd_o.exec      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.fill_load = (state_q == S_FILL);
    cmd_o.out_load  = (state_q == S_HOLD) && sts_i.out_free;
  end

  assign in_stall_o = !cmd_o.idle;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_FILL;
      end
      S_FILL: state_d = S_DIV;
      S_DIV: begin
        if (sts_i.div_last) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // accepted beat is followed by the fill pass
  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> cmd_o.fill_load)
    else $error("fill pass did not follow accepted beat");

  // divider reports its last step after each fill pass
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fill_load |-> ##(PctW) sts_i.div_last)
    else $error("divider length mismatch");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.exec, cmd_o.fill_load, cmd_o.out_load, sts_i.div_last}))
    else $error("overlapping control phases");

endmodule

@@ src/brb_div.sv @@
`timescale 1ns / 1ps
module brb_div
  import brb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NumW-1:0]   num_i,
  input  logic [CapW-1:0]   den_i,
  output logic [PctW-1:0]   quot_o,
  output logic              last_o
);

  localparam int unsigned SW = $clog2(PctW);

  logic [NumW-1:0] rem_q, den_q;
  logic [PctW-1:0] quot_q;
  logic [SW-1:0]   step_q;
  logic            busy_q;
  logic            take;

  // restoring division, one quotient bit per cycle, MSB first
  assign take   = (rem_q >= den_q);
  assign last_o = busy_q && (step_q == SW'(PctW - 1));
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + SW'(1);
      if (last_o) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= NumW'(den_i) << (PctW - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (take) rem_q <= rem_q - den_q;
      den_q  <= den_q >> 1;
      quot_q <= {quot_q[PctW-2:0], take};
    end
  end

endmodule

@@ src/brb_datapath.sv @@
`timescale 1ns / 1ps
module brb_datapath
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_cmd_t       cmd_i,
  input  in_item_t        in_item_i,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_data_i,
  output dp_status_t      sts_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o
);

  localparam int unsigned PW      = $clog2(DEPTH);
  localparam int unsigned XW      = ((PW > CapW) ? PW : CapW) + 1;
  localparam int unsigned CapInit = (CapReset > DEPTH) ? DEPTH : CapReset;

  logic [ByteW-1:0]  mem_q [DEPTH];
  logic [PW-1:0]     rp_q, rp_d, wp_q, wp_d;
  logic [CapW-1:0]   cap_q, cap_d, cap_w;
  logic              empty, is_rd, hit;
  logic              hit_q, ok_q;
  logic [ByteW-1:0]  rd_q;
  logic [XW-1:0]     fill;
  logic [NumW-1:0]   num;
  logic [CountW-1:0] count_q;
  logic [PctW-1:0]   quot;
  logic              div_last;
  logic              out_valid_q;
  out_item_t         out_q;

  function automatic logic [PW-1:0] next_idx(logic [PW-1:0] p, logic [CapW-1:0] cap);
    logic [XW-1:0] n;
    n = XW'(p) + XW'(1);
    if (n >= XW'(cap)) n = '0;
    return n[PW-1:0];
  endfunction

  // capacity write: zero acts as one, above DEPTH saturates
  always_comb begin
    cap_w = cfg_data_i;
    if (cap_w == '0) begin
      cap_w = CapW'(1);
    end else if (32'(cap_w) > DEPTH) begin
      cap_w = CapW'(DEPTH);
    end
  end

  assign empty = (rp_q == wp_q);
  assign is_rd = (in_item_i.command == CmdPop) || (in_item_i.command == CmdPeek);
  assign hit   = cmd_i.exec && is_rd && !empty;

  always_comb begin
    rp_d  = rp_q;
    wp_d  = wp_q;
    cap_d = cap_q;
    if (cfg_we_i) begin
      cap_d = cap_w;
      rp_d  = '0;
      wp_d  = '0;
    end else if (cmd_i.exec) begin
      if (in_item_i.command == CmdPush) begin
        wp_d = next_idx(wp_q, cap_q);
      end else if (hit && (in_item_i.command == CmdPop)) begin
        rp_d = next_idx(rp_q, cap_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      cap_q <= CapW'(CapInit);
      hit_q <= 1'b0;
      ok_q  <= 1'b0;
    end else begin
      rp_q  <= rp_d;
      wp_q  <= wp_d;
      cap_q <= cap_d;
      if (cmd_i.exec) begin
        hit_q <= hit;
        ok_q  <= !(is_rd && empty);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (in_item_i.command == CmdPush)) begin
      mem_q[wp_q] <= in_item_i.write_byte;
    end
    if (hit) begin
      rd_q <= mem_q[rp_q];
    end
  end

  // fill level from the updated pointers; always below capacity
  assign fill = (rp_q <= wp_q) ? (XW'(wp_q) - XW'(rp_q))
                               : (XW'(cap_q) - XW'(rp_q) + XW'(wp_q));
  assign num  = NumW'(fill[CapW-1:0]) * NumW'(PercentScale);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_load) count_q <= fill[CountW-1:0];
  end

  brb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.fill_load),
    .num_i   (num),
    .den_i   (cap_q),
    .quot_o  (quot),
    .last_o  (div_last)
  );

  assign sts_o.div_last = div_last;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.read_byte    <= hit_q ? rd_q : '0;
      out_q.success      <= ok_q;
      out_q.fill_count   <= count_q;
      out_q.fill_percent <= quot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ src/byte_ring_buffer.sv @@
`timescale 1ns / 1ps
// Circular byte FIFO with a run-time capacity.
// Input channel (in_valid_i / in_stall_o / in_item_i): one command per beat,
// push, pop, peek or query. Output channel (out_valid_o / out_stall_i /
// out_item_o): one result beat per command, carrying the byte read, a
// success flag, the fill count and the fill percentage.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes the
// capacity, 0 acts as 1 and values above DEPTH saturate; both indices clear.
// Write it only with no command in flight.
// Each command passes in order through the store access, the fill count and
// multiply by 100, the one-bit-per-cycle percent divider and the load of the
// output register, which waits while a stalled result is still held. A new
// command is taken only once the previous result has been loaded.
// The output register lets the next command be accepted while a result
// waits; a held result blocks only the load of the following one.
// Push never checks for full: a wrap onto the read index makes the FIFO
// look empty. Pop or peek on empty reports success 0 and byte 0.
// Reset: indices zero, capacity min(1024, DEPTH), store contents undefined
// (never read before written). No clearing pass.
module byte_ring_buffer
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CapW-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       cfg_we;

  // config beats are taken only when the sequencer is idle and no command
  // beat is offered, so a write never meets a command on the same edge
  assign cfg_ready_o = cmd.idle && !in_valid_i;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  brb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  brb_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
